// File: src/cisd_pkg.sv
package cisd_pkg;

	localparam int unsigned RF_DEPTH = 256;
	localparam int unsigned RF_AW    = $clog2(RF_DEPTH);

	// register indexes
	localparam logic [7:0] REG_BASE_SEL = 8'h10;
	localparam logic [7:0] REG_BASE_LO  = 8'h12;
	localparam logic [7:0] REG_BASE_HI  = 8'h13;
	localparam logic [7:0] REG_MASK_21  = 8'h21;
	localparam logic [7:0] REG_MASK_22  = 8'h22;
	localparam logic [7:0] REG_SHD_C0   = 8'h25;
	localparam logic [7:0] REG_SHD_C8   = 8'h26;
	localparam logic [7:0] REG_SHD_D0   = 8'h27;
	localparam logic [7:0] REG_SHD_F0   = 8'h28;
	localparam logic [7:0] REG_MASK_29  = 8'h29;
	localparam logic [7:0] REG_MASK_36  = 8'h36;
	localparam logic [7:0] REG_ONES     = 8'h7b;
	localparam logic [7:0] IDX_HIGH     = 8'hc0;

	localparam logic [7:0] SEL_HOST  = 8'h07;
	localparam logic [7:0] SEL_LOCAL = 8'h06;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam int unsigned N_REGIONS = 13;

	typedef struct packed {
		logic       opcode;
		logic       port_is_data;
		logic [7:0] write_data;
	} cisd_item_t;

	typedef struct packed {
		logic [7:0]           read_data;
		logic [N_REGIONS-1:0] shadow_write_enable;
		logic [N_REGIONS-1:0] shadow_read_enable;
		logic                 bios_shadow_write;
		logic                 bios_shadow_read;
		logic                 smram_enable;
		logic [15:0]          host_bus_base;
		logic [15:0]          local_bus_base;
	} cisd_result_t;

	// data-port write as seen by the storage
	typedef struct packed {
		logic       en;
		logic [7:0] idx;
		logic [7:0] raw;
		logic [7:0] masked;
	} cisd_wr_t;

	function automatic logic [7:0] wr_mask(input logic [7:0] idx, input logic [7:0] v);
		logic [7:0] m;
		m = v;
		case (idx)
			REG_MASK_21: m = v & 8'hfe;
			REG_MASK_22: m = v & 8'h7f;
			REG_SHD_F0:  m = v & 8'he3;
			REG_MASK_29: m = v & 8'h0f;
			REG_MASK_36: m = v & 8'h3f;
			default:     m = v;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] rst_val(input logic [7:0] idx);
		return (idx == REG_ONES) ? 8'hff : 8'h00;
	endfunction

endpackage

// File: src/cisd_mem.sv
module cisd_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cisd_pkg::cisd_wr_t           wr,
	input  logic                         rd_en,
	input  logic [cisd_pkg::RF_AW-1:0]   rd_addr,
	output logic [7:0]                   rd_data
);
	import cisd_pkg::*;

	logic [7:0]          mem [RF_DEPTH];
	logic [RF_DEPTH-1:0] vld_q;
	logic [7:0]          data_s1;
	logic                vld_s1;
	logic [RF_AW-1:0]    addr_s1;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.idx[RF_AW-1:0]] <= wr.masked;
		if (rd_en)
			data_s1 <= mem[rd_addr];
	end

	// an entry never written reads back its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_s1  <= 1'b0;
			addr_s1 <= '0;
		end else begin
			if (wr.en)
				vld_q[wr.idx[RF_AW-1:0]] <= 1'b1;
			if (rd_en) begin
				vld_s1  <= vld_q[rd_addr];
				addr_s1 <= rd_addr;
			end
		end
	end

	assign rd_data = vld_s1 ? data_s1 : rst_val(8'(addr_s1));

endmodule

// File: src/cisd_shadow.sv
module cisd_shadow (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cisd_pkg::cisd_wr_t                   wr,
	output logic [cisd_pkg::N_REGIONS-1:0]       wen,
	output logic [cisd_pkg::N_REGIONS-1:0]       ren,
	output logic                                 smram_en,
	output logic [15:0]                          hbus_base,
	output logic [15:0]                          local_base
);
	import cisd_pkg::*;

	logic [7:0]  sel_q;
	logic [7:0]  shd_q [4];
	logic [15:0] host_q;
	logic [15:0] local_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= '0;
			shd_q   <= '{default: '0};
			host_q  <= '0;
			local_q <= '0;
		end else if (wr.en) begin
			case (wr.idx)
				REG_BASE_SEL: sel_q    <= wr.masked;
				REG_SHD_C0:   shd_q[0] <= wr.masked;
				REG_SHD_C8:   shd_q[1] <= wr.masked;
				REG_SHD_D0:   shd_q[2] <= wr.masked;
				REG_SHD_F0:   shd_q[3] <= wr.masked;
				REG_BASE_LO: begin
					if (sel_q == SEL_HOST)
						host_q[7:0] <= wr.raw;
					else if (sel_q == SEL_LOCAL)
						local_q[7:0] <= wr.raw;
				end
				REG_BASE_HI: begin
					if (sel_q == SEL_HOST)
						host_q[15:8] <= wr.raw;
					else if (sel_q == SEL_LOCAL)
						local_q[15:8] <= wr.raw;
				end
				default: ;
			endcase
		end
	end

	// twelve 16K regions take two bits each from 25h..27h; F0000 from 28h[1:0]
	always_comb begin
		for (int i = 0; i < 12; i++) begin
			wen[i] = shd_q[i / 4][2 * (i % 4)];
			ren[i] = shd_q[i / 4][2 * (i % 4) + 1];
		end
		wen[12] = shd_q[3][0];
		ren[12] = shd_q[3][1];
	end

	assign smram_en   = shd_q[3][7];
	assign hbus_base  = host_q;
	assign local_base = local_q;

endmodule

// File: src/chipset_index_regs_shadow_decode_unit.sv
// Index/data port register file with shadow-RAM decode. One byte access per
// clock: start is taken whenever busy is low (busy is never raised), and the
// result follows in the next cycle with done high for that single cycle; the
// receiver cannot stall. The result waits on the registered read of the
// 256-byte register memory. Decode outputs reflect the state after the access.
module chipset_index_regs_shadow_decode_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cisd_pkg::cisd_item_t    item,
	output logic                    done,
	output cisd_pkg::cisd_result_t  result
);
	import cisd_pkg::*;

	localparam logic [1:0] RK_ZERO = 2'd0;
	localparam logic [1:0] RK_IDX  = 2'd1;
	localparam logic [1:0] RK_ONES = 2'd2;
	localparam logic [1:0] RK_MEM  = 2'd3;

	logic       acc;
	logic [7:0] index_q;
	logic [7:0] idx_s1;
	logic [1:0] kind_s1;
	logic       done_q;
	cisd_wr_t   wr;
	logic       rd_en;
	logic [7:0] mem_rd;
	logic [N_REGIONS-1:0] wen, ren;
	logic       smram_en;
	logic [15:0] hbus_base, local_base;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	always_comb begin
		wr.en     = acc && item.opcode == OP_WRITE && item.port_is_data;
		wr.idx    = index_q;
		wr.raw    = item.write_data;
		wr.masked = wr_mask(index_q, item.write_data);
	end

	assign rd_en = acc && item.opcode == OP_READ && item.port_is_data;

	cisd_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (index_q[RF_AW-1:0]),
		.rd_data (mem_rd)
	);

	cisd_shadow u_shadow (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.wen        (wen),
		.ren        (ren),
		.smram_en   (smram_en),
		.hbus_base  (hbus_base),
		.local_base (local_base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			done_q  <= 1'b0;
			kind_s1 <= RK_ZERO;
			idx_s1  <= '0;
		end else begin
			done_q <= acc;
			if (acc) begin
				idx_s1 <= index_q;
				if (item.opcode == OP_WRITE) begin
					kind_s1 <= RK_ZERO;
					if (!item.port_is_data)
						index_q <= item.write_data;
				end else if (!item.port_is_data)
					kind_s1 <= RK_IDX;
				else if (index_q >= IDX_HIGH)
					kind_s1 <= RK_ONES;
				else
					kind_s1 <= RK_MEM;
			end
		end
	end

	always_comb begin
		case (kind_s1)
			RK_IDX:  result.read_data = idx_s1;
			RK_ONES: result.read_data = 8'hff;
			RK_MEM:  result.read_data = mem_rd;
			default: result.read_data = 8'h00;
		endcase
		result.shadow_write_enable = wen;
		result.shadow_read_enable  = ren;
		result.bios_shadow_write   = |wen[N_REGIONS-1:8];
		result.bios_shadow_read    = |ren[N_REGIONS-1:8];
		result.smram_enable        = smram_en;
		result.host_bus_base       = hbus_base;
		result.local_bus_base      = local_base;
	end

	assign done = done_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> done) else $error("accepted item gave no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> !done) else $error("result without an accepted item");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.opcode == OP_WRITE) |=> result.read_data == 8'h00)
		else $error("write access returned nonzero data");

	a_index_load: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.opcode == OP_WRITE && !item.port_is_data)
		|=> index_q == $past(item.write_data))
		else $error("index port write not loaded");

	a_base_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && wr.en && index_q != REG_BASE_LO && index_q != REG_BASE_HI)
		|=> $stable(hbus_base) && $stable(local_base))
		else $error("I/O base moved on unrelated write");

endmodule

// File: tb/chipset_index_regs_shadow_decode_unit_tb.sv
`timescale 1ns / 100ps

module chipset_index_regs_shadow_decode_unit_tb;
	import cisd_pkg::*;

	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	cisd_item_t   bus_access = '0;
	logic         done;
	cisd_result_t port_result;

	chipset_index_regs_shadow_decode_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (bus_access),
		.done   (done),
		.result (port_result)
	);

	always #2 clk = ~clk;

	// shadow copy of the chipset state
	logic [7:0]   cur_index;
	logic [7:0]   chip_regs [RF_DEPTH];
	logic [15:0]  hbus_base;
	logic [15:0]  local_base;

	cisd_item_t   access_q [$];
	cisd_result_t decode_q [$];
	cisd_result_t want;
	int unsigned  send_idle_pct = 0;
	int unsigned  errors = 0;
	int unsigned  cycles = 0;

	function automatic cisd_result_t access_chipset(cisd_item_t acc);
		cisd_result_t r;
		logic [7:0]   v;
		int unsigned  k;
		r = '0;
		if (acc.opcode == OP_WRITE) begin
			if (acc.port_is_data == PORT_DATA) begin
				v = acc.write_data;
				case (cur_index)
					REG_BASE_LO: begin
						if (chip_regs[REG_BASE_SEL] == SEL_HOST)
							hbus_base[7:0] = v;
						else if (chip_regs[REG_BASE_SEL] == SEL_LOCAL)
							local_base[7:0] = v;
					end
					REG_BASE_HI: begin
						if (chip_regs[REG_BASE_SEL] == SEL_HOST)
							hbus_base[15:8] = v;
						else if (chip_regs[REG_BASE_SEL] == SEL_LOCAL)
							local_base[15:8] = v;
					end
					REG_MASK_21: v = v & 8'hfe;
					REG_MASK_22: v = v & 8'h7f;
					REG_SHD_F0:  v = v & 8'he3;
					REG_MASK_29: v = v & 8'h0f;
					REG_MASK_36: v = v & 8'h3f;
					default: ;
				endcase
				// high indexes are still stored, just never read back
				chip_regs[cur_index] = v;
			end else begin
				cur_index = acc.write_data;
			end
		end else if (acc.port_is_data == PORT_INDEX) begin
			r.read_data = cur_index;
		end else if (cur_index >= IDX_HIGH) begin
			r.read_data = 8'hff;
		end else begin
			r.read_data = chip_regs[cur_index];
		end
		// four 16K regions per register, write bit even, read bit odd
		for (k = 0; k < 12; k++) begin
			v = chip_regs[REG_SHD_C0 + k / 4];
			r.shadow_write_enable[k] = v[2 * (k % 4)];
			r.shadow_read_enable[k]  = v[2 * (k % 4) + 1];
		end
		r.shadow_write_enable[12] = chip_regs[REG_SHD_F0][0];
		r.shadow_read_enable[12]  = chip_regs[REG_SHD_F0][1];
		r.bios_shadow_write = |r.shadow_write_enable[12:8];
		r.bios_shadow_read  = |r.shadow_read_enable[12:8];
		r.smram_enable      = chip_regs[REG_SHD_F0][7];
		r.host_bus_base     = hbus_base;
		r.local_bus_base    = local_base;
		return r;
	endfunction

	function automatic cisd_item_t mk_access(logic op, logic port, logic [7:0] data);
		cisd_item_t a;
		a.opcode       = op;
		a.port_is_data = port;
		a.write_data   = data;
		return a;
	endfunction

	function automatic logic [7:0] pick_index();
		logic [7:0] idx;
		case ($urandom_range(19))
			0:  idx = REG_BASE_SEL;
			1:  idx = REG_BASE_LO;
			2:  idx = REG_BASE_HI;
			3:  idx = REG_MASK_21;
			4:  idx = REG_MASK_22;
			5:  idx = REG_SHD_C0;
			6:  idx = REG_SHD_C8;
			7:  idx = REG_SHD_D0;
			8:  idx = REG_SHD_F0;
			9:  idx = REG_MASK_29;
			10: idx = REG_MASK_36;
			11: idx = REG_ONES;
			12: idx = IDX_HIGH - 8'd1;
			13: idx = IDX_HIGH;
			14: idx = 8'hff;
			15: idx = REG_BASE_SEL;
			default: idx = 8'($urandom_range(255));
		endcase
		return idx;
	endfunction

	task automatic queue_random(int unsigned n);
		int unsigned cnt;
		int unsigned reps;
		int unsigned kind;
		logic [7:0]  idx;
		logic [7:0]  data;
		cnt = 0;
		while (cnt < n) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				// index load then a burst of data-port accesses
				idx = pick_index();
				access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, idx));
				reps = $urandom_range(1, 3);
				repeat (reps) begin
					data = 8'($urandom_range(255));
					if (idx == REG_BASE_SEL && $urandom_range(1) == 1)
						data = ($urandom_range(1) == 1) ? SEL_HOST : SEL_LOCAL;
					access_q.push_back(mk_access(1'($urandom_range(1)), PORT_DATA, data));
				end
				cnt += reps + 1;
			end else if (kind < 85) begin
				access_q.push_back(mk_access(OP_READ, PORT_INDEX, 8'($urandom_range(255))));
				cnt++;
			end else begin
				access_q.push_back(mk_access(1'($urandom_range(1)), 1'($urandom_range(1)),
					8'($urandom_range(255))));
				cnt++;
			end
		end
	endtask

	// waits until the sender has gone quiet and every decode has come back; sampled mid-cycle
	task automatic drain();
		do
			@(negedge clk);
		while (access_q.size() != 0 || start || decode_q.size() != 0);
	endtask

	task automatic check_field(string fname, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				decode_q.push_back(access_chipset(bus_access));
			if (!start || !busy) begin
				if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					start      <= 1'b1;
					bus_access <= access_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (decode_q.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, port_result);
				errors++;
			end else begin
				want = decode_q.pop_front();
				check_field("read_data", want.read_data, port_result.read_data);
				check_field("shadow_write_enable", want.shadow_write_enable,
					port_result.shadow_write_enable);
				check_field("shadow_read_enable", want.shadow_read_enable,
					port_result.shadow_read_enable);
				check_field("bios_shadow_write", want.bios_shadow_write,
					port_result.bios_shadow_write);
				check_field("bios_shadow_read", want.bios_shadow_read,
					port_result.bios_shadow_read);
				check_field("smram_enable", want.smram_enable, port_result.smram_enable);
				check_field("host_bus_base", want.host_bus_base, port_result.host_bus_base);
				check_field("local_bus_base", want.local_bus_base, port_result.local_bus_base);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out, %0d results outstanding", $time, decode_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		cur_index  = '0;
		hbus_base  = '0;
		local_base = '0;
		for (int i = 0; i < RF_DEPTH; i++)
			chip_regs[i] = '0;
		chip_regs[REG_ONES] = 8'hff;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 12;
		access_q.push_back(mk_access(OP_READ,  PORT_INDEX, 8'h00));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_ONES));
		access_q.push_back(mk_access(OP_READ,  PORT_DATA,  8'hff));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, IDX_HIGH));
		access_q.push_back(mk_access(OP_READ,  PORT_DATA,  8'h00));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_MASK_21));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'hff));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_MASK_22));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'hff));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_SHD_F0));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'hff));
		access_q.push_back(mk_access(OP_READ,  PORT_DATA,  8'h00));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_MASK_29));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'hff));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_MASK_36));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'hff));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_BASE_SEL));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  SEL_HOST));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_BASE_LO));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'h34));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_BASE_SEL));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  SEL_LOCAL));
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, REG_BASE_HI));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'hab));
		// stored at a high index, though such indexes read back as all ones
		access_q.push_back(mk_access(OP_WRITE, PORT_INDEX, 8'hff));
		access_q.push_back(mk_access(OP_WRITE, PORT_DATA,  8'h00));
		queue_random(470);
		drain();

		send_idle_pct = 66;
		queue_random(470);
		drain();

		send_idle_pct = 0;
		queue_random(470);
		drain();

		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
